[rtl/branching_extinction_probability_defines.svh]
// Assertion macros used by the branching extinction probability checker.
`ifndef BRANCHING_EXTINCTION_PROBABILITY_DEFINES_SVH
`define BRANCHING_EXTINCTION_PROBABILITY_DEFINES_SVH

// Same-cycle implication, reset disables the check.
`define BEP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bep check failed");

// Next-cycle implication, reset disables the check.
`define BEP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bep check failed");

`endif

[rtl/bep_pkg.sv]
// Shared types and constants of the branching extinction probability block.
`timescale 1ns / 1ps
package bep_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    typedef logic [CFG_W-1:0]     cfg_word_t;
    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_GENERATIONS        = 1'b0;
    localparam cfg_index_t REG_INITIAL_POPULATION = 1'b1;

endpackage

[rtl/bep_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bep_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 1024
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/bep_mul.sv]
// Bit-serial fixed-point multiplier: prod = floor(a * b / 2^FRAC_BITS).
`timescale 1ns / 1ps
module bep_mul #(
    parameter int FRAC_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [FRAC_BITS:0]   a,
    input  logic [FRAC_BITS:0]   b,
    output logic                 done,
    output logic [FRAC_BITS:0]   prod
);

    localparam int W  = FRAC_BITS + 1;
    localparam int SW = $clog2(FRAC_BITS + 1);

    logic [W-1:0]  a_reg;
    logic [W-1:0]  b_reg;
    logic [W:0]    p_reg;
    logic [SW-1:0] step_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [W:0]    sum;

    // LSB first: add, then drop one bit; the top bit of b weighs 1.0 and skips the shift
    assign sum  = p_reg + {1'b0, (b_reg[0] ? a_reg : {W{1'b0}})};
    assign done = done_reg;
    assign prod = p_reg[W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == SW'(FRAC_BITS))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                step_reg <= step_reg + SW'(1);
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
            p_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == SW'(FRAC_BITS))
            begin
                p_reg <= sum;
            end
            else
            begin
                p_reg <= sum >> 1;
                b_reg <= b_reg >> 1;
            end
        end
    end

endmodule

[rtl/branching_extinction_probability.sv]
// Top level: Galton-Watson extinction probability with a bit-serial multiplier.
`timescale 1ns / 1ps
//
// Channel   | Dir | Handshake                     | Payload
// ----------+-----+-------------------------------+-----------------------------------
// s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata: class_probability; tlast
// m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: extinction_probability
// cfg       | in  | cfg_wen (no wait)             | cfg_index, cfg_data
//
// Loading accepts one request per cycle in S_LOAD; probabilities up to the store depth land in the store RAM.
// After the request with tlast, input stalls while the shared serial multiplier
// runs: n-1 products per generation for n classes, then up to 2*16 products
// for the power stage.
// A finished result sits in the output register; the next set loads meanwhile.
// Reset clears control state only; the store needs no clearing pass.
module branching_extinction_probability
    import bep_pkg::*;
#(
    parameter int MAX_CLASSES = 1024,
    parameter int FRAC_BITS   = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [FRAC_BITS:0] class_probability, rest zero padding
    input  logic [((FRAC_BITS + 1 + 7) / 8) * 8-1:0] s_axis_tdata,
    input  logic                                   s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [FRAC_BITS:0] extinction_probability, rest zero padding
    output logic [((FRAC_BITS + 1 + 7) / 8) * 8-1:0] m_axis_tdata,
    input  logic                                   cfg_wen,
    input  cfg_index_t                             cfg_index,
    input  cfg_word_t                              cfg_data
);

    localparam int W   = FRAC_BITS + 1;
    localparam int TDW = ((FRAC_BITS + 1 + 7) / 8) * 8;
    localparam int AW  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int CW  = $clog2(MAX_CLASSES + 1);
    localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic [3:0] S_LOAD      = 4'd0;
    localparam logic [3:0] S_GEN_START = 4'd1;
    localparam logic [3:0] S_GEN_READ  = 4'd2;
    localparam logic [3:0] S_GEN_INIT  = 4'd3;
    localparam logic [3:0] S_H_MUL     = 4'd4;
    localparam logic [3:0] S_H_WAIT    = 4'd5;
    localparam logic [3:0] S_GEN_END   = 4'd6;
    localparam logic [3:0] S_POW_INIT  = 4'd7;
    localparam logic [3:0] S_POW_CHECK = 4'd8;
    localparam logic [3:0] S_POW_RMUL  = 4'd9;
    localparam logic [3:0] S_POW_RWAIT = 4'd10;
    localparam logic [3:0] S_POW_SMUL  = 4'd11;
    localparam logic [3:0] S_POW_SWAIT = 4'd12;
    localparam logic [3:0] S_OUT       = 4'd13;

    logic [3:0]    state_reg;
    cfg_word_t     generations_reg;
    cfg_word_t     population_reg;
    cfg_word_t     gen_cnt_reg;
    cfg_word_t     exp_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] j_reg;
    logic [CW-1:0] j_minus1;
    logic [W-1:0]  f_reg;      // current generation value
    logic [W-1:0]  acc_reg;    // Horner accumulator
    logic [W-1:0]  res_reg;
    logic [W-1:0]  base_reg;
    logic [W-1:0]  out_data_reg;
    logic          out_valid_reg;

    logic          s_accept;
    logic          store_we;
    logic [W-1:0]  p_in;
    logic [W-1:0]  rd_data;
    logic          mul_start;
    logic [W-1:0]  mul_a;
    logic [W-1:0]  mul_b;
    logic          mul_done;
    logic [W-1:0]  mul_prod;
    logic [W:0]    h_sum;
    logic [W-1:0]  h_sat;

    assign s_axis_tready = (state_reg == S_LOAD);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(TDW - W){1'b0}}, out_data_reg};

    // saturate incoming probabilities to 1.0; requests past the store depth are dropped
    assign p_in     = (s_axis_tdata[W-1:0] > ONE) ? ONE : s_axis_tdata[W-1:0];
    assign store_we = s_accept && (count_reg < CW'(MAX_CLASSES));

    // read address tracks j-1, held steady across a whole multiply
    assign j_minus1 = j_reg - CW'(1);

    bep_ram #(
        .WIDTH(W),
        .DEPTH(MAX_CLASSES)
    ) u_store (
        .clk  (clk),
        .we   (store_we),
        .waddr(count_reg[AW-1:0]),
        .wdata(p_in),
        .raddr(j_minus1[AW-1:0]),
        .rdata(rd_data)
    );

    // one multiplier shared by Horner steps, power multiplies and squarings
    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = acc_reg;
        mul_b     = f_reg;
        case (state_reg)
            S_H_MUL:
            begin
                mul_start = 1'b1;
            end
            S_POW_RMUL:
            begin
                mul_start = 1'b1;
                mul_a     = res_reg;
                mul_b     = base_reg;
            end
            S_POW_SMUL:
            begin
                mul_start = 1'b1;
                mul_a     = base_reg;
                mul_b     = base_reg;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    bep_mul #(
        .FRAC_BITS(FRAC_BITS)
    ) u_mul (
        .clk  (clk),
        .rst_n(rst_n),
        .start(mul_start),
        .a    (mul_a),
        .b    (mul_b),
        .done (mul_done),
        .prod (mul_prod)
    );

    // Horner step: acc*f + p[j-1], clipped at 1.0
    assign h_sum = {1'b0, mul_prod} + {1'b0, rd_data};
    assign h_sat = (h_sum > {1'b0, ONE}) ? ONE : h_sum[W-1:0];

    // control: sequencer state, counters, config and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_LOAD;
            generations_reg <= cfg_word_t'(1);
            population_reg  <= cfg_word_t'(1);
            gen_cnt_reg     <= '0;
            exp_reg         <= '0;
            count_reg       <= '0;
            j_reg           <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_GENERATIONS:        generations_reg <= cfg_data;
                    REG_INITIAL_POPULATION: population_reg  <= cfg_data;
                    default:                generations_reg <= generations_reg;
                endcase
            end

            // result register: filled from S_OUT, emptied once taken
            if ((state_reg == S_OUT) && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_LOAD:
                begin
                    if (s_accept)
                    begin
                        if (store_we)
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                        if (s_axis_tlast)
                        begin
                            gen_cnt_reg <= '0;
                            state_reg   <= S_GEN_START;
                        end
                    end
                end
                S_GEN_START:
                begin
                    if (gen_cnt_reg == generations_reg)
                    begin
                        state_reg <= S_POW_INIT;
                    end
                    else
                    begin
                        j_reg     <= count_reg;
                        state_reg <= S_GEN_READ;
                    end
                end
                S_GEN_READ:
                begin
                    state_reg <= S_GEN_INIT;
                end
                S_GEN_INIT:
                begin
                    j_reg <= j_minus1;
                    if (j_minus1 == '0)
                    begin
                        state_reg <= S_GEN_END;
                    end
                    else
                    begin
                        state_reg <= S_H_MUL;
                    end
                end
                S_H_MUL:
                begin
                    state_reg <= S_H_WAIT;
                end
                S_H_WAIT:
                begin
                    if (mul_done)
                    begin
                        j_reg <= j_minus1;
                        if (j_minus1 == '0)
                        begin
                            state_reg <= S_GEN_END;
                        end
                        else
                        begin
                            state_reg <= S_H_MUL;
                        end
                    end
                end
                S_GEN_END:
                begin
                    // a fixed point stays fixed: skip the remaining generations
                    if (acc_reg == f_reg)
                    begin
                        state_reg <= S_POW_INIT;
                    end
                    else
                    begin
                        gen_cnt_reg <= gen_cnt_reg + cfg_word_t'(1);
                        state_reg   <= S_GEN_START;
                    end
                end
                S_POW_INIT:
                begin
                    exp_reg   <= population_reg;
                    state_reg <= S_POW_CHECK;
                end
                S_POW_CHECK:
                begin
                    if (exp_reg == '0)
                    begin
                        state_reg <= S_OUT;
                    end
                    else if (exp_reg[0])
                    begin
                        state_reg <= S_POW_RMUL;
                    end
                    else
                    begin
                        state_reg <= S_POW_SMUL;
                    end
                end
                S_POW_RMUL:
                begin
                    state_reg <= S_POW_RWAIT;
                end
                S_POW_RWAIT:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_POW_SMUL;
                    end
                end
                S_POW_SMUL:
                begin
                    state_reg <= S_POW_SWAIT;
                end
                S_POW_SWAIT:
                begin
                    if (mul_done)
                    begin
                        exp_reg   <= exp_reg >> 1;
                        state_reg <= S_POW_CHECK;
                    end
                end
                S_OUT:
                begin
                    // wait for the output register to free up
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        count_reg <= '0;
                        state_reg <= S_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_LOAD:
            begin
                if (s_accept && s_axis_tlast)
                begin
                    f_reg <= '0;
                end
            end
            S_GEN_INIT:
            begin
                acc_reg <= rd_data;
            end
            S_H_WAIT:
            begin
                if (mul_done)
                begin
                    acc_reg <= h_sat;
                end
            end
            S_GEN_END:
            begin
                f_reg <= acc_reg;
            end
            S_POW_INIT:
            begin
                res_reg  <= ONE;
                base_reg <= f_reg;
            end
            S_POW_RWAIT:
            begin
                if (mul_done)
                begin
                    res_reg <= mul_prod;
                end
            end
            S_POW_SWAIT:
            begin
                if (mul_done)
                begin
                    base_reg <= mul_prod;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_reg <= res_reg;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

endmodule

[rtl/bep_checker.sv]
// Port-level checker for the branching extinction probability block, with bind.
`timescale 1ns / 1ps
`include "branching_extinction_probability_defines.svh"
module bep_checker #(
    parameter int FRAC_BITS = 32
) (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   s_axis_tvalid,
    input logic                                   s_axis_tready,
    input logic                                   s_axis_tlast,
    input logic                                   m_axis_tvalid,
    input logic                                   m_axis_tready,
    input logic [((FRAC_BITS + 1 + 7) / 8) * 8-1:0] m_axis_tdata
);

    // stalled result holds
    `BEP_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // a request without tlast never produces a result
    `BEP_ASSERT_NEXT(a_no_spurious, clk, rst_n, s_axis_tvalid && s_axis_tready && !s_axis_tlast && !m_axis_tvalid, !m_axis_tvalid)

    // the end of a set stalls input while the iteration runs
    `BEP_ASSERT_NEXT(a_busy_after_last, clk, rst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)

    // results never exceed 1.0
    `BEP_ASSERT_NOW(a_out_range, clk, rst_n, m_axis_tvalid, (m_axis_tdata[FRAC_BITS] == 1'b0) || (m_axis_tdata[FRAC_BITS-1:0] == '0))

endmodule

bind branching_extinction_probability bep_checker #(
    .FRAC_BITS(FRAC_BITS)
) u_bep_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
